// ----- rtl/lrx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrx_pkg: shared types and constants of the crossover
// Sample, coefficient and accumulator types, register indexes and the
// rounding and saturation helpers of the filter datapath.
// ----------------------------------------------------------------------------
package lrx_pkg;

   // payload and coefficient types
   typedef logic signed [23:0] sample_type;   // Q1.23
   typedef logic signed [31:0] coef_type;     // Q5.27
   typedef logic signed [31:0] hist_type;     // Q1.31
   typedef logic signed [27:0] taps_type;     // integer tap sum of Q1.23 samples
   typedef logic signed [59:0] ff_type;       // gain * taps, 50 fraction bits
   typedef logic signed [63:0] acc_type;      // accumulator, 50 fraction bits

   localparam int unsigned HIST_DEPTH      = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned FB_ALIGN_SHIFT  = 8;
   localparam int unsigned HIST_SHIFT      = 19;
   localparam int unsigned OUT_SHIFT       = 27;

   // binomial tap weights
   localparam taps_type TAP_FOUR = 28'sd4;
   localparam taps_type TAP_SIX  = 28'sd6;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOWPASS_GAIN   = 3'd0,
      CSR_HIGHPASS_GAIN  = 3'd1,
      CSR_FEEDBACK_ONE   = 3'd2,
      CSR_FEEDBACK_TWO   = 3'd3,
      CSR_FEEDBACK_THREE = 3'd4,
      CSR_FEEDBACK_FOUR  = 3'd5
   } csr_index_type;

   // rounding offsets and saturation limits in accumulator scale
   localparam acc_type HIST_HALF = 64'sd1 <<< (HIST_SHIFT - 1);
   localparam acc_type OUT_HALF  = 64'sd1 <<< (OUT_SHIFT - 1);
   localparam acc_type HIST_MAX  = 64'sh0000_0000_7FFF_FFFF;
   localparam acc_type HIST_MIN  = -64'sh0000_0000_8000_0000;
   localparam acc_type OUT_MAX   = 64'sh0000_0000_007F_FFFF;
   localparam acc_type OUT_MIN   = -64'sh0000_0000_0080_0000;

   // round half up to Q1.31, saturate to 32 bits
   function automatic hist_type sat_hist(acc_type acc);
      acc_type r;
      r = (acc + HIST_HALF) >>> HIST_SHIFT;
      if (r > HIST_MAX) begin
         r = HIST_MAX;
      end else if (r < HIST_MIN) begin
         r = HIST_MIN;
      end
      return r[31:0];
   endfunction

   // round half up to Q1.23, saturate to 24 bits
   function automatic sample_type sat_out(acc_type acc);
      acc_type r;
      r = (acc + OUT_HALF) >>> OUT_SHIFT;
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      return r[23:0];
   endfunction

endpackage : lrx_pkg
`default_nettype wire

// ----- rtl/lrx_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrx_if: stream channels of the crossover
// Valid/ready channels for input samples and for band result pairs.
// ----------------------------------------------------------------------------
interface lrx_req_if;
   logic                valid;
   logic                ready;
   lrx_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface : lrx_req_if

interface lrx_rsp_if;
   logic                valid;
   logic                ready;
   lrx_pkg::sample_type low_band;
   lrx_pkg::sample_type high_band;

   modport source (output valid, output low_band, output high_band, input ready);
   modport sink   (input valid, input low_band, input high_band, output ready);
endinterface : lrx_rsp_if
`default_nettype wire

// ----- rtl/linkwitz_riley_crossover.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover: 4th-order two-band audio crossover
// Splits each Q1.23 sample into a low band and a high band through two
// direct-form IIR filters sharing input history and feedback coefficients.
// ----------------------------------------------------------------------------
// Usage:
// - req_ch carries one signed Q1.23 sample per transfer; rsp_ch carries the
//   matching low_band / high_band pair, one transfer per input, in order.
// - Coefficients (Q5.27) are loaded through csr_write_enable / csr_index /
//   csr_write_data; out-of-range indexes are ignored. The user must load
//   them only while the block is idle; the block does not enforce this.
// - Three register stages: tap sums, feed-forward products, then the
//   feedback products, accumulation, rounding and saturation.
// - One sample per cycle while rsp_ch is ready; the output history loop
//   (four 32x32 feedback products and their sum) closes in the last stage.
// - When rsp_ch stalls, the result holds and empty stages still fill, so
//   up to two more samples are taken before req_ch.ready drops.
// - Reset (synchronous, active high) clears all coefficients, the input and
//   output histories and every stage valid.
// ----------------------------------------------------------------------------
module linkwitz_riley_crossover (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   lrx_req_if.sink                                     req_ch,
   lrx_rsp_if.source                                   rsp_ch,
   input  wire logic                                   csr_write_enable,
   input  wire logic [lrx_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [31:0]                            csr_write_data
);

   // configuration registers
   lrx_pkg::coef_type lowpass_gain_ff;
   lrx_pkg::coef_type highpass_gain_ff;
   lrx_pkg::coef_type feedback_ff [lrx_pkg::HIST_DEPTH];

   // filter state
   lrx_pkg::sample_type input_hist_ff [lrx_pkg::HIST_DEPTH];
   lrx_pkg::hist_type   low_hist_ff   [lrx_pkg::HIST_DEPTH];
   lrx_pkg::hist_type   high_hist_ff  [lrx_pkg::HIST_DEPTH];

   // stage registers
   logic                s1_valid_ff;
   lrx_pkg::taps_type   low_taps_ff;
   lrx_pkg::taps_type   high_taps_ff;
   logic                s2_valid_ff;
   lrx_pkg::ff_type     low_ff_ff;
   lrx_pkg::ff_type     high_ff_ff;
   logic                rsp_valid_ff;
   lrx_pkg::sample_type low_band_ff;
   lrx_pkg::sample_type high_band_ff;

   // next values
   lrx_pkg::taps_type   low_taps_in;
   lrx_pkg::taps_type   high_taps_in;
   lrx_pkg::ff_type     low_ff_in;
   lrx_pkg::ff_type     high_ff_in;
   lrx_pkg::acc_type    low_acc;
   lrx_pkg::acc_type    high_acc;
   lrx_pkg::hist_type   low_hist_in;
   lrx_pkg::hist_type   high_hist_in;
   lrx_pkg::sample_type low_band_in;
   lrx_pkg::sample_type high_band_in;

   // stage handshake
   logic out_take;
   logic s2_go;
   logic s2_take;
   logic s1_go;
   logic s1_take;
   logic req_xfer;

   // stage handshake: a stage loads when it is empty or drains this cycle
   always_comb begin
      out_take = !rsp_valid_ff || rsp_ch.ready;
      s2_go    = s2_valid_ff && out_take;
      s2_take  = !s2_valid_ff || s2_go;
      s1_go    = s1_valid_ff && s2_take;
      s1_take  = !s1_valid_ff || s1_go;
      req_xfer = req_ch.valid && s1_take;
   end

   assign req_ch.ready     = s1_take;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.low_band  = low_band_ff;
   assign rsp_ch.high_band = high_band_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lowpass_gain_ff  <= '0;
         highpass_gain_ff <= '0;
         for (int k = 0; k < lrx_pkg::HIST_DEPTH; k++) begin
            feedback_ff[k] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lrx_pkg::CSR_LOWPASS_GAIN:   lowpass_gain_ff  <= csr_write_data;
            lrx_pkg::CSR_HIGHPASS_GAIN:  highpass_gain_ff <= csr_write_data;
            lrx_pkg::CSR_FEEDBACK_ONE:   feedback_ff[0]   <= csr_write_data;
            lrx_pkg::CSR_FEEDBACK_TWO:   feedback_ff[1]   <= csr_write_data;
            lrx_pkg::CSR_FEEDBACK_THREE: feedback_ff[2]   <= csr_write_data;
            lrx_pkg::CSR_FEEDBACK_FOUR:  feedback_ff[3]   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage 1: binomial tap sums over the new sample and input history
   always_comb begin
      lrx_pkg::taps_type x0;
      lrx_pkg::taps_type x1;
      lrx_pkg::taps_type x2;
      lrx_pkg::taps_type x3;
      lrx_pkg::taps_type x4;
      x0 = lrx_pkg::taps_type'(req_ch.sample);
      x1 = lrx_pkg::taps_type'(input_hist_ff[0]);
      x2 = lrx_pkg::taps_type'(input_hist_ff[1]);
      x3 = lrx_pkg::taps_type'(input_hist_ff[2]);
      x4 = lrx_pkg::taps_type'(input_hist_ff[3]);
      low_taps_in  = x0 + lrx_pkg::TAP_FOUR * x1 + lrx_pkg::TAP_SIX * x2
                   + lrx_pkg::TAP_FOUR * x3 + x4;
      high_taps_in = x0 - lrx_pkg::TAP_FOUR * x1 + lrx_pkg::TAP_SIX * x2
                   - lrx_pkg::TAP_FOUR * x3 + x4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int k = 0; k < lrx_pkg::HIST_DEPTH; k++) begin
            input_hist_ff[k] <= '0;
         end
      end else begin
         if (req_xfer) begin
            s1_valid_ff      <= 1'b1;
            input_hist_ff[0] <= req_ch.sample;
            for (int k = 1; k < lrx_pkg::HIST_DEPTH; k++) begin
               input_hist_ff[k] <= input_hist_ff[k-1];
            end
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         low_taps_ff  <= low_taps_in;
         high_taps_ff <= high_taps_in;
      end
   end

   // stage 2: feed-forward products, gain times tap sum
   always_comb begin
      low_ff_in  = lrx_pkg::ff_type'(lowpass_gain_ff)  * lrx_pkg::ff_type'(low_taps_ff);
      high_ff_in = lrx_pkg::ff_type'(highpass_gain_ff) * lrx_pkg::ff_type'(high_taps_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         low_ff_ff  <= low_ff_in;
         high_ff_ff <= high_ff_in;
      end
   end

   // stage 3: feedback products aligned by floor shift, then accumulate
   always_comb begin
      lrx_pkg::acc_type low_fb;
      lrx_pkg::acc_type high_fb;
      low_acc  = lrx_pkg::acc_type'(low_ff_ff);
      high_acc = lrx_pkg::acc_type'(high_ff_ff);
      for (int k = 0; k < lrx_pkg::HIST_DEPTH; k++) begin
         low_fb   = lrx_pkg::acc_type'(feedback_ff[k])
                  * lrx_pkg::acc_type'(low_hist_ff[k]);
         high_fb  = lrx_pkg::acc_type'(feedback_ff[k])
                  * lrx_pkg::acc_type'(high_hist_ff[k]);
         low_acc  = low_acc  - (low_fb  >>> lrx_pkg::FB_ALIGN_SHIFT);
         high_acc = high_acc - (high_fb >>> lrx_pkg::FB_ALIGN_SHIFT);
      end
      low_hist_in  = lrx_pkg::sat_hist(low_acc);
      high_hist_in = lrx_pkg::sat_hist(high_acc);
      low_band_in  = lrx_pkg::sat_out(low_acc);
      high_band_in = lrx_pkg::sat_out(high_acc);
   end

   // output register and output history
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < lrx_pkg::HIST_DEPTH; k++) begin
            low_hist_ff[k]  <= '0;
            high_hist_ff[k] <= '0;
         end
      end else begin
         if (s2_go) begin
            rsp_valid_ff    <= 1'b1;
            low_hist_ff[0]  <= low_hist_in;
            high_hist_ff[0] <= high_hist_in;
            for (int k = 1; k < lrx_pkg::HIST_DEPTH; k++) begin
               low_hist_ff[k]  <= low_hist_ff[k-1];
               high_hist_ff[k] <= high_hist_ff[k-1];
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         low_band_ff  <= low_band_in;
         high_band_ff <= high_band_in;
      end
   end

   // checks on the stage control
   a_take_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted sample did not reach stage 1");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_take) |=> (s1_valid_ff && $stable(low_taps_ff)))
      else $error("stalled stage 1 lost or changed its item");

   a_s2_reaches_out : assert property (@(posedge clock) disable iff (reset)
      s2_go |=> rsp_valid_ff)
      else $error("stage 2 item did not reach the output register");

   a_hist_frozen : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=>
         ($stable(low_hist_ff[0]) && $stable(high_hist_ff[0])))
      else $error("output history moved while the result was stalled");

endmodule : linkwitz_riley_crossover
`default_nettype wire

// ----- sim/lrx_band_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrx_band_scoreboard_pkg: band predictor and scoreboard of the crossover
// Predicts the low and high band pair of every accepted sample in 64-bit
// fixed point, queues the pairs in order and checks each result transfer.
// ----------------------------------------------------------------------------
package lrx_band_scoreboard_pkg;
   import lrx_pkg::*;

   typedef struct packed {
      sample_type low_band;
      sample_type high_band;
   } band_pair_type;

   localparam int          BAND_LOW     = 0;
   localparam int          BAND_HIGH    = 1;
   localparam int unsigned REPORT_LIMIT = 10;

   // saturation bounds of the output history and of the band samples
   localparam longint HISTORY_TOP    = 64'sd2147483647;
   localparam longint HISTORY_BOTTOM = -64'sd2147483648;
   localparam longint BAND_TOP       = 64'sd8388607;
   localparam longint BAND_BOTTOM    = -64'sd8388608;

   class band_scoreboard;
      coef_type      lowpass_gain;
      coef_type      highpass_gain;
      coef_type      feedback [HIST_DEPTH];
      sample_type    sample_history [HIST_DEPTH];
      hist_type      output_history [2][HIST_DEPTH];
      band_pair_type expected_bands [$];
      int unsigned   band_errors;

      function new();
         lowpass_gain  = '0;
         highpass_gain = '0;
         band_errors   = 0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            feedback[k]                  = '0;
            sample_history[k]            = '0;
            output_history[BAND_LOW][k]  = '0;
            output_history[BAND_HIGH][k] = '0;
         end
      endfunction

      // register write; spare indexes hold nothing
      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
         case (index)
            CSR_LOWPASS_GAIN:   lowpass_gain  = data;
            CSR_HIGHPASS_GAIN:  highpass_gain = data;
            CSR_FEEDBACK_ONE:   feedback[0]   = data;
            CSR_FEEDBACK_TWO:   feedback[1]   = data;
            CSR_FEEDBACK_THREE: feedback[2]   = data;
            CSR_FEEDBACK_FOUR:  feedback[3]   = data;
            default: ;
         endcase
      endfunction

      // one direct-form section: feed-forward minus aligned feedback
      function sample_type filter_band(int band, coef_type gain, longint taps);
         longint acc;
         longint rounded;
         longint hist_half;
         longint band_half;
         hist_half = longint'(1) <<< (HIST_SHIFT - 1);
         band_half = longint'(1) <<< (OUT_SHIFT - 1);
         acc = longint'(gain) * taps;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            acc -= (longint'(feedback[k]) * longint'(output_history[band][k]))
                   >>> FB_ALIGN_SHIFT;
         end
         // new history entry in Q1.31
         rounded = (acc + hist_half) >>> HIST_SHIFT;
         if (rounded > HISTORY_TOP) begin
            rounded = HISTORY_TOP;
         end else if (rounded < HISTORY_BOTTOM) begin
            rounded = HISTORY_BOTTOM;
         end
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            output_history[band][k] = output_history[band][k-1];
         end
         output_history[band][0] = rounded[31:0];
         // band sample in Q1.23
         rounded = (acc + band_half) >>> OUT_SHIFT;
         if (rounded > BAND_TOP) begin
            rounded = BAND_TOP;
         end else if (rounded < BAND_BOTTOM) begin
            rounded = BAND_BOTTOM;
         end
         return rounded[23:0];
      endfunction

      // accepted sample: predict its band pair
      function void take_sample(sample_type sample);
         longint        x [HIST_DEPTH+1];
         longint        low_taps;
         longint        high_taps;
         band_pair_type pair;
         x[0] = longint'(sample);
         for (int k = 0; k < HIST_DEPTH; k++) begin
            x[k+1] = longint'(sample_history[k]);
         end
         low_taps  = x[0] + longint'(TAP_FOUR) * x[1] + longint'(TAP_SIX) * x[2]
                     + longint'(TAP_FOUR) * x[3] + x[4];
         high_taps = x[0] - longint'(TAP_FOUR) * x[1] + longint'(TAP_SIX) * x[2]
                     - longint'(TAP_FOUR) * x[3] + x[4];
         pair.low_band  = filter_band(BAND_LOW, lowpass_gain, low_taps);
         pair.high_band = filter_band(BAND_HIGH, highpass_gain, high_taps);
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            sample_history[k] = sample_history[k-1];
         end
         sample_history[0] = sample;
         expected_bands.push_back(pair);
      endfunction

      function void note_error(string what, sample_type want, sample_type got);
         band_errors++;
         if (band_errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      // accepted result transfer against the oldest prediction
      function void check_bands(sample_type low_band, sample_type high_band);
         band_pair_type want;
         if (expected_bands.size() == 0) begin
            band_errors++;
            if (band_errors <= REPORT_LIMIT) begin
               $display("%0t: unexpected result low %0d high %0d", $time, low_band, high_band);
            end
            return;
         end
         want = expected_bands.pop_front();
         if (low_band !== want.low_band) begin
            note_error("low_band", want.low_band, low_band);
         end
         if (high_band !== want.high_band) begin
            note_error("high_band", want.high_band, high_band);
         end
      endfunction

      function int unsigned pending();
         return expected_bands.size();
      endfunction
   endclass : band_scoreboard

endpackage : lrx_band_scoreboard_pkg

// ----- sim/linkwitz_riley_crossover_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linkwitz_riley_crossover_tb: self-checking bench of the crossover
// Loads several coefficient sets (stable pole pairs, random words and range
// extremes), streams samples under varied sender and receiver idling and a
// long receiver hold-off, and checks every band pair against a predictor.
// ----------------------------------------------------------------------------
module linkwitz_riley_crossover_tb;
   import lrx_pkg::*;
   import lrx_band_scoreboard_pkg::*;

   localparam int unsigned HALF_PERIOD      = 4;
   localparam int unsigned RESET_CYCLES     = 8;
   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned RANDOM_PHASES    = 8;
   localparam int unsigned PHASE_ITEMS      = 175;
   localparam int unsigned PRESSURE_PHASE   = 4;
   localparam int unsigned REGISTER_SLOTS   = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_SIX   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_SEVEN = 3'd7;

   // idling modes
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   localparam coef_type   COEF_MAX   = 32'sh7FFF_FFFF;
   localparam coef_type   COEF_MIN   = 32'sh8000_0000;
   localparam sample_type SAMPLE_MAX = 24'sh7F_FFFF;
   localparam sample_type SAMPLE_MIN = 24'sh80_0000;
   localparam real        Q27_ONE    = 134217728.0;
   localparam real        PI         = 3.14159265358979;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0]                csr_write_data;
   logic                       hold_off_request;
   int unsigned                send_idle_pct;
   int unsigned                recv_stall_pct;
   int unsigned                hold_left;
   int unsigned                cycle_count;
   logic [31:0]                register_image [REGISTER_SLOTS];
   sample_type                 last_sample;
   band_scoreboard             bands;

   lrx_req_if req_ch ();
   lrx_rsp_if rsp_ch ();

   linkwitz_riley_crossover dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linkwitz_riley_crossover_tb NOT OK");
         $finish;
      end
   end

   // result side: check transfers, random stalls and the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         bands.check_bands(rsp_ch.low_band, rsp_ch.high_band);
      end
      if (hold_off_request) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_off_request <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // offer one sample, with random gaps ahead of it, until it transfers
   task automatic send_sample(sample_type sample);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
      bands.take_sample(sample);
      last_sample = sample;
   endtask

   // stop offering and wait for every predicted pair to come back
   task automatic drain_bands();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (bands.pending() != 0);
   endtask

   // write all register slots, spare ones included
   task automatic program_registers();
      for (int i = 0; i < REGISTER_SLOTS; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= i[CSR_INDEX_WIDTH-1:0];
         csr_write_data   <= register_image[i];
         @(posedge clock);
         bands.write_register(i[CSR_INDEX_WIDTH-1:0], register_image[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic void set_idle_mode(int mode);
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct = 65;
            recv_stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct <= 65;
         end
         IDLE_BOTH: begin
            send_idle_pct = 29;
            recv_stall_pct <= 29;
         end
         default: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end
      endcase
   endfunction

   function automatic void fill_spares();
      register_image[CSR_SPARE_SIX]   = $urandom;
      register_image[CSR_SPARE_SEVEN] = $urandom;
   endfunction

   // two random complex pole pairs inside the unit circle, unity gain at
   // dc for the low band and at nyquist for the high band
   function automatic void pick_stable_filter();
      real c [HIST_DEPTH+1];
      real radius;
      real angle;
      real b1;
      real b2;
      real low_sum;
      real high_sum;
      c[0] = 1.0;
      for (int k = 1; k <= HIST_DEPTH; k++) c[k] = 0.0;
      repeat (2) begin
         radius = 0.3 + 0.68 * $urandom_range(0, 1000) / 1000.0;
         angle  = PI * $urandom_range(0, 1000) / 1000.0;
         b1 = -2.0 * radius * $cos(angle);
         b2 = radius * radius;
         for (int k = HIST_DEPTH; k >= 2; k--) c[k] = c[k] + b1 * c[k-1] + b2 * c[k-2];
         c[1] = c[1] + b1 * c[0];
      end
      low_sum  = c[0] + c[1] + c[2] + c[3] + c[4];
      high_sum = c[0] - c[1] + c[2] - c[3] + c[4];
      register_image[CSR_LOWPASS_GAIN]   = $rtoi(low_sum / 16.0 * Q27_ONE);
      register_image[CSR_HIGHPASS_GAIN]  = $rtoi(high_sum / 16.0 * Q27_ONE);
      register_image[CSR_FEEDBACK_ONE]   = $rtoi(c[1] * Q27_ONE);
      register_image[CSR_FEEDBACK_TWO]   = $rtoi(c[2] * Q27_ONE);
      register_image[CSR_FEEDBACK_THREE] = $rtoi(c[3] * Q27_ONE);
      register_image[CSR_FEEDBACK_FOUR]  = $rtoi(c[4] * Q27_ONE);
      fill_spares();
   endfunction

   function automatic void pick_random_registers();
      for (int i = 0; i < REGISTER_SLOTS; i++) register_image[i] = $urandom;
   endfunction

   // each register at the top, the bottom or zero
   function automatic void pick_extreme_registers();
      for (int i = 0; i < REGISTER_SLOTS; i++) begin
         case ($urandom_range(0, 2))
            0:       register_image[i] = COEF_MAX;
            1:       register_image[i] = COEF_MIN;
            default: register_image[i] = '0;
         endcase
      end
      fill_spares();
   endfunction

   // mostly full-range noise, with held steps, quiet passages and extremes
   function automatic sample_type next_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       s = SAMPLE_MAX;
               1:       s = SAMPLE_MIN;
               2:       s = '0;
               default: s = -24'sd1;
            endcase
         end
         1, 2:    s = last_sample;
         3, 4, 5: s = sample_type'(int'($urandom_range(0, 8191)) - 4096);
         default: s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   initial begin
      sample_type ff_samples [8];
      clock            = 1'b0;
      reset            = 1'b1;
      cycle_count      = 0;
      hold_left        = 0;
      hold_off_request = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      last_sample      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample    = '0;
      rsp_ch.ready     = 1'b0;
      bands            = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // coefficients still at reset: both bands stay at zero
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_bands();

      // full-scale gains of opposite sign and no feedback: saturation both ways
      register_image[CSR_LOWPASS_GAIN]   = COEF_MAX;
      register_image[CSR_HIGHPASS_GAIN]  = COEF_MIN;
      register_image[CSR_FEEDBACK_ONE]   = '0;
      register_image[CSR_FEEDBACK_TWO]   = '0;
      register_image[CSR_FEEDBACK_THREE] = '0;
      register_image[CSR_FEEDBACK_FOUR]  = '0;
      fill_spares();
      program_registers();
      ff_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
                     SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1};
      foreach (ff_samples[i]) send_sample(ff_samples[i]);
      drain_bands();

      // four poles at one half: impulse, then a negative full-scale step
      register_image[CSR_LOWPASS_GAIN]   = 32'sd524288;
      register_image[CSR_HIGHPASS_GAIN]  = 32'sd42467328;
      register_image[CSR_FEEDBACK_ONE]   = -32'sd268435456;
      register_image[CSR_FEEDBACK_TWO]   = 32'sd201326592;
      register_image[CSR_FEEDBACK_THREE] = -32'sd67108864;
      register_image[CSR_FEEDBACK_FOUR]  = 32'sd8388608;
      fill_spares();
      program_registers();
      send_sample(SAMPLE_MAX);
      repeat (5) send_sample('0);
      repeat (4) send_sample(SAMPLE_MIN);
      repeat (2) send_sample('0);
      drain_bands();

      // random phases over coefficient kinds and idling modes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            1:       pick_random_registers();
            3:       pick_extreme_registers();
            default: pick_stable_filter();
         endcase
         program_registers();
         set_idle_mode(phase % 4);
         if (phase == PRESSURE_PHASE) begin
            hold_off_request <= 1'b1;
         end
         repeat (PHASE_ITEMS) send_sample(next_sample());
         drain_bands();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bands.band_errors == 0 && bands.pending() == 0) begin
         $display("linkwitz_riley_crossover_tb OK");
      end else begin
         $display("linkwitz_riley_crossover_tb NOT OK");
      end
      $finish;
   end

endmodule : linkwitz_riley_crossover_tb

// ----- files.f -----
rtl/lrx_pkg.sv
rtl/lrx_if.sv
rtl/linkwitz_riley_crossover.sv
sim/lrx_band_scoreboard_pkg.sv
sim/linkwitz_riley_crossover_tb.sv
